FILE: rtl/core/pli_pkg.sv
package pli_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int ELEM_WIDTH_DEF = 32;

    // fixed field widths of the stream items
    localparam int FUNC_W  = 2;
    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 5;
    localparam int TDATA_W = 40;

    // cell index compare width (covers any capacity up to 256)
    localparam int CELL_IDX_W = 9;

    localparam logic [FUNC_W-1:0] FN_READ   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [POS_W-1:0] idx;   // 0-based target entry
    } pli_cmd_t;

endpackage

FILE: rtl/core/pli_cell.sv
module pli_cell #(
    parameter int IDX        = 0,
    parameter int ELEM_WIDTH = pli_pkg::ELEM_WIDTH_DEF
) (
    input  logic                    clk,
    input  pli_pkg::pli_cmd_t       cmd,
    input  logic [ELEM_WIDTH-1:0]   new_val,
    input  logic [ELEM_WIDTH-1:0]   left_val,
    input  logic [ELEM_WIDTH-1:0]   right_val,
    output logic [ELEM_WIDTH-1:0]   val
);
    import pli_pkg::*;

    localparam logic [CELL_IDX_W-1:0] MY_IDX = CELL_IDX_W'(IDX);

    logic [CELL_IDX_W-1:0] tgt;
    logic [ELEM_WIDTH-1:0] val_reg;
    logic [ELEM_WIDTH-1:0] val_next;

    assign tgt = CELL_IDX_W'(cmd.idx);

    always_comb
    begin
        val_next = val_reg;
        if (cmd.ins)
        begin
            if (MY_IDX > tgt)
                val_next = left_val;
            else if (MY_IDX == tgt)
                val_next = new_val;
        end
        else if (cmd.del)
        begin
            if (MY_IDX >= tgt)
                val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

FILE: rtl/core/positional_list_insert_delete_top.sv
// Positional list: ordered store of up to CAPACITY entries, addressed by
// 1-based position.
// Input stream (s_*): one transfer per operation - read, insert or delete at
// a position. Insert moves the entries at and above the position up one
// place, delete moves the entries above it down one place.
// Output stream (m_*): exactly one transfer per operation, in order, with a
// status code, the value read (zero unless a successful read) and the list
// length after the operation.
// Latency: the result is presented in the cycle after the input transfer.
// Throughput: one operation per clock while the output is not stalled; the row
// of entry cells shifts its whole contents at once on the accepting clock edge.
// A failed operation leaves the list untouched.
// Stall: the result sits in the output register until m_tready; while it
// waits, s_tready stays low unless the result is taken in the same cycle.
// Reset: clears the length to zero and drops any pending result; entry
// contents are not cleared, as positions beyond the length are never read.
module positional_list_insert_delete_top #(
    parameter int CAPACITY   = pli_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH = pli_pkg::ELEM_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [1:0] func, [6:2] position, [38:7] elem_value, [39] zero
    input  logic [pli_pkg::TDATA_W-1:0] s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [1:0] status, [33:2] read_value, [38:34] list_length, [39] zero
    output logic [pli_pkg::TDATA_W-1:0] m_tdata
);
    import pli_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W + 1) ? CW : POS_W + 1;

    // input fields
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  elem_value;

    assign func       = s_tdata[1:0];
    assign position   = s_tdata[6:2];
    assign elem_value = s_tdata[38:7];

    // element cut or widened to the entry width
    logic [63:0]           elem_ext;
    logic [ELEM_WIDTH-1:0] new_val;

    assign elem_ext = 64'(elem_value);
    assign new_val  = elem_ext[ELEM_WIDTH-1:0];

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic              out_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic [VAL_W-1:0]  rdval_reg;
    logic [VAL_W-1:0]  rdval_next;
    logic [LEN_W-1:0]  len_reg;

    logic fire;
    assign s_tready = !out_valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;

    logic [CMPW-1:0]  posx;
    logic [CMPW-1:0]  cntx;
    logic [POS_W-1:0] idx;
    logic             pos_in_list;   // 1 .. length
    logic             pos_insertable; // 1 .. length+1
    logic             is_full;
    logic             is_empty;

    assign posx           = CMPW'(position);
    assign cntx           = CMPW'(count_reg);
    assign idx            = position - POS_W'(1);
    assign pos_in_list    = (position != '0) && (posx <= cntx);
    assign pos_insertable = (position != '0) && (posx <= cntx + CMPW'(1));
    assign is_full        = (cntx == CMPW'(CAPACITY));
    assign is_empty       = (count_reg == '0);

    // entry row
    logic [ELEM_WIDTH-1:0] cell_val [CAPACITY];
    pli_cmd_t              cmd;

    // read select: each cell compared with the target index
    logic [ELEM_WIDTH-1:0] rd_sel;
    logic [63:0]           rd_ext;

    always_comb
    begin
        rd_sel = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (CELL_IDX_W'(i) == CELL_IDX_W'(idx))
                rd_sel = rd_sel | cell_val[i];
        end
    end

    assign rd_ext = 64'(rd_sel);

    // decode of the operation
    always_comb
    begin
        cmd         = '0;
        cmd.idx     = idx;
        count_next  = count_reg;
        status_next = ST_RANGE;
        rdval_next  = '0;
        case (func)
            FN_READ:
            begin
                if (pos_in_list)
                begin
                    status_next = ST_OK;
                    rdval_next  = rd_ext[VAL_W-1:0];
                end
            end
            FN_INSERT:
            begin
                if (is_full)
                    status_next = ST_FULL;
                else if (pos_insertable)
                begin
                    status_next = ST_OK;
                    cmd.ins     = fire;
                    count_next  = count_reg + CW'(1);
                end
            end
            FN_DELETE:
            begin
                if (is_empty)
                    status_next = ST_EMPTY;
                else if (pos_in_list)
                begin
                    status_next = ST_OK;
                    cmd.del     = fire;
                    count_next  = count_reg - CW'(1);
                end
            end
            default:
            begin
                status_next = ST_RANGE;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [ELEM_WIDTH-1:0] left_v;
            logic [ELEM_WIDTH-1:0] right_v;

            if (g == 0)
            begin : g_first
                assign left_v = new_val;
            end
            else
            begin : g_mid_l
                assign left_v = cell_val[g-1];
            end

            // top cell takes zero when an entry is removed
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_v = '0;
            end
            else
            begin : g_mid_r
                assign right_v = cell_val[g+1];
            end

            pli_cell #(
                .IDX        (g),
                .ELEM_WIDTH (ELEM_WIDTH)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .new_val   (new_val),
                .left_val  (left_v),
                .right_val (right_v),
                .val       (cell_val[g])
            );
        end
    endgenerate

    // length and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= status_next;
            rdval_reg  <= rdval_next;
            len_reg    <= LEN_W'(count_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, len_reg, rdval_reg, status_reg};

endmodule

FILE: rtl/core/pli_check.sv
module pli_check #(
    parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [pli_pkg::TDATA_W-1:0] s_tdata,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [pli_pkg::TDATA_W-1:0] m_tdata
);
    import pli_pkg::*;

    logic [STAT_W-1:0] m_status;
    logic [VAL_W-1:0]  m_rdval;
    logic [LEN_W-1:0]  m_len;
    logic              s_busy;

    assign m_status = m_tdata[1:0];
    assign m_rdval  = m_tdata[33:2];
    assign m_len    = m_tdata[38:34];
    assign s_busy   = s_tvalid && (s_tdata[39] == 1'b0);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // full answer only on a list at capacity
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_status == ST_FULL) |-> (m_len == LEN_W'(CAPACITY)))
        else $error("full status with list not at capacity");

    // empty answer only on an empty list
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_status == ST_EMPTY) |-> (m_len == '0))
        else $error("empty status with entries held");

    // a value is only returned by a successful operation
    a_rdval: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_rdval != '0) |-> (m_status == ST_OK))
        else $error("read value on a failed operation");

    // an input transfer with bit 39 zero always yields a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_busy && s_tready |=> m_tvalid)
        else $error("transfer without result");

endmodule

bind positional_list_insert_delete_top pli_check #(
    .CAPACITY (CAPACITY)
) u_pli_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pli_pkg::*;

    localparam int LIST_DEPTH = CAPACITY_DEF;

    // func value with no operation behind it; the block answers out of range
    localparam logic [FUNC_W-1:0] FN_UNDEF = 2'd3;

    // random stimulus leanings, so the list is driven to full and back to empty
    localparam int LEAN_FILL     = 0;
    localparam int LEAN_BALANCED = 1;
    localparam int LEAN_DRAIN    = 2;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  read_value;
        logic [LEN_W-1:0]  list_length;
    } list_result_t;

    // Shadow copy of the list. Every accepted operation is applied here and
    // its expected answer queued; answers from the block are checked in order.
    class list_scoreboard;
        logic [VAL_W-1:0] entries [LIST_DEPTH];
        int unsigned      length;
        list_result_t     answer_q [$];
        int               error_count;

        function new();
            length = 0;
            error_count = 0;
            foreach (entries[i])
                entries[i] = '0;
        endfunction

        function int pending();
            return answer_q.size();
        endfunction

        // apply one accepted operation to the shadow list
        function void note_op(logic [FUNC_W-1:0] func, logic [POS_W-1:0] pos,
                              logic [VAL_W-1:0] value);
            list_result_t ans;
            int           p;
            int           i;
            p = pos;
            ans.status = ST_OK;
            ans.read_value = '0;
            case (func)
                FN_READ:
                    if (p < 1 || p > length)
                        ans.status = ST_RANGE;
                    else
                        ans.read_value = entries[p-1];
                FN_INSERT:
                    if (length >= LIST_DEPTH)
                        ans.status = ST_FULL;
                    else if (p < 1 || p > length + 1)
                        ans.status = ST_RANGE;
                    else
                    begin
                        for (i = length; i > p - 1; i--)
                            entries[i] = entries[i-1];
                        entries[p-1] = value;
                        length++;
                    end
                FN_DELETE:
                    if (length == 0)
                        ans.status = ST_EMPTY;
                    else if (p < 1 || p > length)
                        ans.status = ST_RANGE;
                    else
                    begin
                        for (i = p - 1; i + 1 < length; i++)
                            entries[i] = entries[i+1];
                        entries[length-1] = '0;
                        length--;
                    end
                default:
                    ans.status = ST_RANGE;
            endcase
            ans.list_length = length[LEN_W-1:0];
            answer_q.push_back(ans);
        endfunction

        task report(string msg);
            $display("ERROR at %0t ns: %s", $time, msg);
            error_count++;
        endtask

        task check_result(logic [TDATA_W-1:0] tdata);
            list_result_t want;
            logic [STAT_W-1:0] got_status;
            logic [VAL_W-1:0]  got_value;
            logic [LEN_W-1:0]  got_length;
            got_status = tdata[1:0];
            got_value  = tdata[33:2];
            got_length = tdata[38:34];
            if (answer_q.size() == 0)
            begin
                report($sformatf("unexpected result transfer, tdata %h", tdata));
                return;
            end
            want = answer_q.pop_front();
            if (got_status !== want.status)
                report($sformatf("status %0d, expected %0d", got_status, want.status));
            if (got_value !== want.read_value)
                report($sformatf("read_value %h, expected %h", got_value, want.read_value));
            if (got_length !== want.list_length)
                report($sformatf("list_length %0d, expected %0d",
                                 got_length, want.list_length));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    // [1:0] func, [6:2] position, [38:7] elem_value, [39] zero
    logic [TDATA_W-1:0] s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // [1:0] status, [33:2] read_value, [38:34] list_length, [39] zero
    logic [TDATA_W-1:0] m_tdata;

    // percentages of cycles in which the sender holds back / the receiver stalls
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    list_scoreboard list_sb = new();

    positional_list_insert_delete_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // result transfers are checked against the oldest expectation
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            list_sb.check_result(m_tdata);

    // Drives one operation and returns at the edge on which its transfer
    // completes. Idle gaps go in front, so s_tvalid only drops between items.
    task send_op(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                 input logic [VAL_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, value, pos, func};
        do
            @(posedge clk);
        while (!s_tready);
        list_sb.note_op(func, pos, value);
    endtask

    // One random operation. Positions are mostly legal for the current length,
    // with a share of arbitrary ones to hit the range and empty/full checks.
    task send_random_op(input int lean);
        int               pick;
        int unsigned      len;
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  value;
        len  = list_sb.length;
        pick = $urandom_range(99);
        case (lean)
            LEAN_FILL:
                func = (pick < 60) ? FN_INSERT : (pick < 80) ? FN_READ :
                       (pick < 97) ? FN_DELETE : FN_UNDEF;
            LEAN_DRAIN:
                func = (pick < 20) ? FN_INSERT : (pick < 45) ? FN_READ :
                       (pick < 97) ? FN_DELETE : FN_UNDEF;
            default:
                func = (pick < 35) ? FN_INSERT : (pick < 65) ? FN_READ :
                       (pick < 97) ? FN_DELETE : FN_UNDEF;
        endcase
        if ($urandom_range(9) == 0)
            pos = POS_W'($urandom_range(31));
        else if (func == FN_INSERT)
            pos = (len >= LIST_DEPTH) ? POS_W'($urandom_range(31)) :
                                        POS_W'($urandom_range(len + 1, 1));
        else
            pos = (len == 0) ? POS_W'($urandom_range(31)) :
                               POS_W'($urandom_range(len, 1));
        case ($urandom_range(15))
            0:       value = '0;
            1:       value = '1;
            default: value = $urandom;
        endcase
        send_op(func, pos, value);
    endtask

    initial
    begin
        int n;
        int ph;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling: empty-list corners first
        send_op(FN_READ,   5'd0, 32'h0);          // out of range on empty list
        send_op(FN_READ,   5'd1, 32'h0);          // any read of empty list
        send_op(FN_DELETE, 5'd0, 32'h0);          // empty wins over bad position
        send_op(FN_INSERT, 5'd0, 32'h1234_5678);  // position zero
        send_op(FN_INSERT, 5'd2, 32'h1234_5678);  // beyond length+1
        send_op(FN_UNDEF,  5'd0, 32'hFFFF_FFFF);  // undefined selector
        // build [0, 5A.., F.., A5..] from front, append and middle inserts
        send_op(FN_INSERT, 5'd1, 32'hFFFF_FFFF);
        send_op(FN_INSERT, 5'd1, 32'h0000_0000);
        send_op(FN_INSERT, 5'd3, 32'hA5A5_A5A5);
        send_op(FN_INSERT, 5'd2, 32'h5A5A_5A5A);
        send_op(FN_READ,   5'd1, 32'hFFFF_FFFF);  // value ignored on read
        send_op(FN_READ,   5'd4, 32'h0);
        send_op(FN_READ,   5'd5, 32'h0);          // one past the end
        send_op(FN_READ,   5'd31, 32'h0);
        send_op(FN_DELETE, 5'd5, 32'h0);          // one past the end
        send_op(FN_DELETE, 5'd31, 32'hFFFF_FFFF);
        send_op(FN_DELETE, 5'd2, 32'h0);          // middle, upper entries shift down
        send_op(FN_DELETE, 5'd3, 32'h0);          // top entry
        send_op(FN_READ,   5'd2, 32'h0);
        send_op(FN_READ,   5'd3, 32'h0);          // slot just vacated
        send_op(FN_UNDEF,  5'd1, 32'h0);

        // random part: five phases of back-pressure, leaning in 40-item chunks
        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
                3:       begin send_idle_pct = 35; recv_stall_pct = 35; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            for (n = 0; n < 100; n++)
            begin
                case (((ph * 100 + n) / 40) % 4)
                    0:       send_random_op(LEAN_FILL);
                    2:       send_random_op(LEAN_DRAIN);
                    default: send_random_op(LEAN_BALANCED);
                endcase
            end
        end

        s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (list_sb.pending() != 0)
            @(posedge clk);
        // spare cycles catch any stray transfer
        repeat (10) @(posedge clk);

        if (list_sb.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/pli_pkg.sv
rtl/core/pli_cell.sv
rtl/core/positional_list_insert_delete_top.sv
rtl/core/pli_check.sv
sim/testbench.sv
